// File: hdl/quaternion_multiply_rotate_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the quaternion block.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_MULTIPLY_ROTATE_ASSERT_SVH
`define QUATERNION_MULTIPLY_ROTATE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define QMR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quaternion block check failed");

// next-cycle implication, sampled on clk, off during reset
`define QMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quaternion block check failed");

`endif

// File: hdl/qmr_pkg.sv
// ----------------------------------------------------------------------------
// qmr_pkg
// Types, widths, term tables and helper functions of the quaternion block.
// ----------------------------------------------------------------------------
package qmr_pkg;

    typedef enum logic {
        OP_PRODUCT = 1'b0,
        OP_ROTATE  = 1'b1
    } op_t;

    localparam int WORD = 32;
    localparam int PW   = 64;
    localparam int SW   = 66;
    localparam int CW   = 67;
    localparam int NLW  = 65;
    localparam int NW   = 100;
    localparam int RW   = 101;
    localparam int DW   = 66;
    localparam int QW   = 34;

    // A-product index: ww xx yy zz xy xz yz wx wy wz
    // vector select: 0 = x, 1 = y, 2 = z
    localparam int TERM_PA [3][8] = '{
        '{0, 1, 2, 3, 4, 9, 5, 8},
        '{4, 9, 0, 1, 2, 3, 6, 7},
        '{5, 8, 6, 7, 0, 1, 2, 3}
    };
    localparam int TERM_B [3][8] = '{
        '{0, 0, 0, 0, 1, 1, 2, 2},
        '{0, 0, 1, 1, 1, 1, 2, 2},
        '{0, 0, 1, 1, 2, 2, 2, 2}
    };
    localparam int TERM_K [3][8] = '{
        '{1, 1, -1, -1, 2, -2, 2, 2},
        '{2, 2, 1, -1, 1, -1, 2, -2},
        '{2, -2, 2, 2, 1, -1, -1, 1}
    };

    typedef struct packed {
        op_t                  op;
        logic                 zl;
        logic [NLW-1:0]       n;
        logic [3:0][WORD-1:0] pr;
        logic                 psat;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic [2:0]           neg;
        logic [2:0][RW-1:0]   rem;
        logic [2:0][QW-1:0]   quo;
        logic [DW-1:0]        den;
    } div_t;

    function automatic logic signed [PW-1:0] mul32(input logic signed [WORD-1:0] a,
                                                   input logic signed [WORD-1:0] b);
        mul32 = a * b;
    endfunction

    function automatic logic signed [PW:0] mul_lo(input logic [WORD-1:0] a,
                                                  input logic signed [WORD-1:0] b);
        logic signed [WORD:0] as;
        as = {1'b0, a};
        mul_lo = as * b;
    endfunction

    // {clamped, word} from sign and magnitude
    function automatic logic [WORD:0] clamp32(input logic neg, input logic [CW-1:0] m);
        if (neg)
        begin
            if (m > CW'(33'h0_8000_0000))
                clamp32 = {1'b1, 32'h8000_0000};
            else
                clamp32 = {1'b0, WORD'(CW'(0) - m)};
        end
        else
        begin
            if (m > CW'(32'h7FFF_FFFF))
                clamp32 = {1'b1, 32'h7FFF_FFFF};
            else
                clamp32 = {1'b0, m[WORD-1:0]};
        end
    endfunction

endpackage

// File: hdl/qmr_in_if.sv
// ----------------------------------------------------------------------------
// qmr_in_if
// Input channel of the quaternion block: operation, quaternion A, operand B.
// ----------------------------------------------------------------------------
interface qmr_in_if;
    logic               valid;
    logic               ready;
    qmr_pkg::op_t       operation;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;

    modport source (output valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                    input ready);
    modport sink (input valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  output ready);
endinterface

// File: hdl/qmr_out_if.sv
// ----------------------------------------------------------------------------
// qmr_out_if
// Result channel of the quaternion block: saturated quaternion and flags.
// ----------------------------------------------------------------------------
interface qmr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic               saturated;
    logic               zero_length;

    modport source (output valid, r_w, r_x, r_y, r_z, saturated, zero_length,
                    input ready);
    modport sink (input valid, r_w, r_x, r_y, r_z, saturated, zero_length,
                  output ready);
endinterface

// File: hdl/quaternion_multiply_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate
// Hamilton product A*B or vector rotation A*v*A^-1 in signed Q16.16.
// ----------------------------------------------------------------------------
// Channels: din takes one beat per item (operation, A, B); dout returns one
// beat per item (r_w..r_z, saturated, zero_length), in order.
// Throughput: one beat per cycle, a new item may enter every cycle unless
// dout stalls. Path from an accepted din beat to its dout beat: five
// multiply and sum stages, one divider setup stage, 34 divider stages (one
// quotient bit each, which sets the depth) and the output register.
// Product rounds to nearest at FRAC_BITS, ties away from zero. Rotate divides
// the exact numerator by |A|^2, rounds to nearest, ties away from zero.
// A zero A in rotate gives zeros with zero_length set.
// Reset clears all valid bits; nothing is in flight.
// When dout stalls, the whole pipeline holds and din.ready drops in the same
// cycle, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
`include "quaternion_multiply_rotate_assert.svh"

module quaternion_multiply_rotate #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    qmr_in_if.sink     din,
    qmr_out_if.source  dout
);

    localparam int WORD = qmr_pkg::WORD;
    localparam int PW   = qmr_pkg::PW;
    localparam int SW   = qmr_pkg::SW;
    localparam int CW   = qmr_pkg::CW;
    localparam int NLW  = qmr_pkg::NLW;
    localparam int NW   = qmr_pkg::NW;
    localparam int RW   = qmr_pkg::RW;
    localparam int QW   = qmr_pkg::QW;

    function automatic logic [WORD:0] prod_fin(input logic signed [SW-1:0] s);
        logic           neg;
        logic [SW-1:0]  m;
        logic [CW-1:0]  mr;
        neg = s[SW-1];
        m   = neg ? SW'(-s) : SW'(s);
        mr  = CW'(m) + (CW'(1) << (FRAC_BITS - 1));
        prod_fin = qmr_pkg::clamp32(neg, mr >> FRAC_BITS);
    endfunction

    logic en;

    // stage 1: raw products
    logic                     v1_reg;
    qmr_pkg::op_t             op1_reg;
    logic signed [WORD-1:0]   b1_reg  [3];
    logic signed [PW-1:0]     pp1_reg [16];
    logic signed [PW-1:0]     pa1_reg [10];
    logic signed [PW-1:0]     pp1_next [16];
    logic signed [PW-1:0]     pa1_next [10];

    // stage 2: partial products of the rotate terms, product sums
    logic                     v2_reg;
    qmr_pkg::op_t             op2_reg;
    logic                     zl2_reg;
    logic [NLW-1:0]           n2_reg;
    logic signed [SW-1:0]     ps2_reg [4];
    logic signed [PW-1:0]     mh2_reg [3][8];
    logic signed [PW:0]       ml2_reg [3][8];
    logic [NLW-1:0]           n2_next;
    logic signed [SW-1:0]     ps2_next [4];
    logic signed [PW-1:0]     mh2_next [3][8];
    logic signed [PW:0]       ml2_next [3][8];

    // stage 3: weighted terms, rounded product
    logic                     v3_reg;
    qmr_pkg::side_t           side3_reg;
    logic signed [NW-1:0]     tk3_reg [3][8];
    qmr_pkg::side_t           side3_next;
    logic signed [NW-1:0]     tk3_next [3][8];
    logic [WORD:0]            pf3 [4];
    logic signed [NW-1:0]     t3 [3][8];

    // stage 4 and 5: numerator sums
    logic                     v4_reg;
    qmr_pkg::side_t           side4_reg;
    logic signed [NW-1:0]     h4_reg [3][2];
    logic signed [NW-1:0]     h4_next [3][2];
    logic                     v5_reg;
    qmr_pkg::side_t           side5_reg;
    logic signed [NW-1:0]     s5_reg [3];
    logic signed [NW-1:0]     s5_next [3];

    // divider
    logic                     div_v_reg [QW+1];
    qmr_pkg::div_t            div_reg   [QW+1];
    qmr_pkg::div_t            div_next  [QW+1];
    logic [NW-1:0]            mag0 [3];

    // output
    logic                     out_valid_reg;
    qmr_pkg::op_t             op_reg;
    logic [WORD-1:0]          r_w_reg;
    logic [WORD-1:0]          r_x_reg;
    logic [WORD-1:0]          r_y_reg;
    logic [WORD-1:0]          r_z_reg;
    logic                     sat_reg;
    logic                     zl_reg;
    logic [WORD:0]            cl [3];
    logic [WORD-1:0]          r_w_next;
    logic [WORD-1:0]          r_x_next;
    logic [WORD-1:0]          r_y_next;
    logic [WORD-1:0]          r_z_next;
    logic                     sat_next;
    logic                     zl_next;

    assign en        = !out_valid_reg || dout.ready;
    assign din.ready = en;

    always_comb
    begin
        pp1_next[0]  = qmr_pkg::mul32(din.a_w, din.b_w);
        pp1_next[1]  = qmr_pkg::mul32(din.a_x, din.b_x);
        pp1_next[2]  = qmr_pkg::mul32(din.a_y, din.b_y);
        pp1_next[3]  = qmr_pkg::mul32(din.a_z, din.b_z);
        pp1_next[4]  = qmr_pkg::mul32(din.a_w, din.b_x);
        pp1_next[5]  = qmr_pkg::mul32(din.a_x, din.b_w);
        pp1_next[6]  = qmr_pkg::mul32(din.a_y, din.b_z);
        pp1_next[7]  = qmr_pkg::mul32(din.a_z, din.b_y);
        pp1_next[8]  = qmr_pkg::mul32(din.a_w, din.b_y);
        pp1_next[9]  = qmr_pkg::mul32(din.a_y, din.b_w);
        pp1_next[10] = qmr_pkg::mul32(din.a_z, din.b_x);
        pp1_next[11] = qmr_pkg::mul32(din.a_x, din.b_z);
        pp1_next[12] = qmr_pkg::mul32(din.a_w, din.b_z);
        pp1_next[13] = qmr_pkg::mul32(din.a_z, din.b_w);
        pp1_next[14] = qmr_pkg::mul32(din.a_x, din.b_y);
        pp1_next[15] = qmr_pkg::mul32(din.a_y, din.b_x);
        pa1_next[0]  = qmr_pkg::mul32(din.a_w, din.a_w);
        pa1_next[1]  = qmr_pkg::mul32(din.a_x, din.a_x);
        pa1_next[2]  = qmr_pkg::mul32(din.a_y, din.a_y);
        pa1_next[3]  = qmr_pkg::mul32(din.a_z, din.a_z);
        pa1_next[4]  = qmr_pkg::mul32(din.a_x, din.a_y);
        pa1_next[5]  = qmr_pkg::mul32(din.a_x, din.a_z);
        pa1_next[6]  = qmr_pkg::mul32(din.a_y, din.a_z);
        pa1_next[7]  = qmr_pkg::mul32(din.a_w, din.a_x);
        pa1_next[8]  = qmr_pkg::mul32(din.a_w, din.a_y);
        pa1_next[9]  = qmr_pkg::mul32(din.a_w, din.a_z);
    end

    always_comb
    begin
        n2_next = NLW'(pa1_reg[0]) + NLW'(pa1_reg[1]) + NLW'(pa1_reg[2]) + NLW'(pa1_reg[3]);
        ps2_next[0] = SW'(pp1_reg[0]) - SW'(pp1_reg[1]) - SW'(pp1_reg[2])
                    - SW'(pp1_reg[3]);
        ps2_next[1] = SW'(pp1_reg[4]) + SW'(pp1_reg[5]) + SW'(pp1_reg[6])
                    - SW'(pp1_reg[7]);
        ps2_next[2] = SW'(pp1_reg[8]) + SW'(pp1_reg[9]) + SW'(pp1_reg[10])
                    - SW'(pp1_reg[11]);
        ps2_next[3] = SW'(pp1_reg[12]) + SW'(pp1_reg[13]) + SW'(pp1_reg[14])
                    - SW'(pp1_reg[15]);
        for (int c = 0; c < 3; c++)
        begin
            for (int t = 0; t < 8; t++)
            begin
                mh2_next[c][t] = qmr_pkg::mul32(
                    pa1_reg[qmr_pkg::TERM_PA[c][t]][PW-1:WORD],
                    b1_reg[qmr_pkg::TERM_B[c][t]]);
                ml2_next[c][t] = qmr_pkg::mul_lo(
                    pa1_reg[qmr_pkg::TERM_PA[c][t]][WORD-1:0],
                    b1_reg[qmr_pkg::TERM_B[c][t]]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pf3[i] = prod_fin(ps2_reg[i]);
        end
        side3_next.op   = op2_reg;
        side3_next.zl   = zl2_reg;
        side3_next.n    = n2_reg;
        side3_next.psat = pf3[0][WORD] | pf3[1][WORD] | pf3[2][WORD] | pf3[3][WORD];
        for (int i = 0; i < 4; i++)
        begin
            side3_next.pr[i] = pf3[i][WORD-1:0];
        end
        for (int c = 0; c < 3; c++)
        begin
            for (int t = 0; t < 8; t++)
            begin
                t3[c][t] = (NW'(mh2_reg[c][t]) <<< WORD) + NW'(ml2_reg[c][t]);
                case (qmr_pkg::TERM_K[c][t])
                    2:       tk3_next[c][t] = t3[c][t] <<< 1;
                    -2:      tk3_next[c][t] = -(t3[c][t] <<< 1);
                    -1:      tk3_next[c][t] = -t3[c][t];
                    default: tk3_next[c][t] = t3[c][t];
                endcase
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            h4_next[c][0] = tk3_reg[c][0] + tk3_reg[c][1] + tk3_reg[c][2] + tk3_reg[c][3];
            h4_next[c][1] = tk3_reg[c][4] + tk3_reg[c][5] + tk3_reg[c][6] + tk3_reg[c][7];
            s5_next[c]    = h4_reg[c][0] + h4_reg[c][1];
        end
    end

    // divider setup: sign/magnitude, num = 2|N| + n, den = 2n
    always_comb
    begin
        div_next[0].side = side5_reg;
        div_next[0].den  = {side5_reg.n, 1'b0};
        for (int c = 0; c < 3; c++)
        begin
            div_next[0].neg[c] = s5_reg[c][NW-1];
            mag0[c]            = s5_reg[c][NW-1] ? NW'(-s5_reg[c]) : NW'(s5_reg[c]);
            div_next[0].rem[c] = RW'({mag0[c], 1'b0}) + RW'(side5_reg.n);
            div_next[0].quo[c] = '0;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        logic [RW-1:0] dsh;
        logic [2:0]    hit;

        always_comb
        begin
            dsh = RW'(div_reg[k-1].den) << (QW - k);
            div_next[k] = div_reg[k-1];
            for (int c = 0; c < 3; c++)
            begin
                hit[c] = div_reg[k-1].rem[c] >= dsh;
                div_next[k].rem[c] = hit[c] ? div_reg[k-1].rem[c] - dsh
                                            : div_reg[k-1].rem[c];
                div_next[k].quo[c] = {div_reg[k-1].quo[c][QW-2:0], hit[c]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_v_reg[k] <= 1'b0;
            else if (en)
                div_v_reg[k] <= div_v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                div_reg[k] <= div_next[k];
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cl[c] = qmr_pkg::clamp32(div_reg[QW].neg[c], CW'(div_reg[QW].quo[c]));
        end
        unique case (div_reg[QW].side.op)
            qmr_pkg::OP_PRODUCT:
            begin
                r_w_next = div_reg[QW].side.pr[0];
                r_x_next = div_reg[QW].side.pr[1];
                r_y_next = div_reg[QW].side.pr[2];
                r_z_next = div_reg[QW].side.pr[3];
                sat_next = div_reg[QW].side.psat;
                zl_next  = 1'b0;
            end
            default:
            begin
                r_w_next = '0;
                if (div_reg[QW].side.zl)
                begin
                    r_x_next = '0;
                    r_y_next = '0;
                    r_z_next = '0;
                    sat_next = 1'b0;
                    zl_next  = 1'b1;
                end
                else
                begin
                    r_x_next = cl[0][WORD-1:0];
                    r_y_next = cl[1][WORD-1:0];
                    r_z_next = cl[2][WORD-1:0];
                    sat_next = cl[0][WORD] | cl[1][WORD] | cl[2][WORD];
                    zl_next  = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            div_v_reg[0]  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= din.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            div_v_reg[0]  <= v5_reg;
            out_valid_reg <= div_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg   <= din.operation;
            b1_reg[0] <= din.b_x;
            b1_reg[1] <= din.b_y;
            b1_reg[2] <= din.b_z;
            pp1_reg   <= pp1_next;
            pa1_reg   <= pa1_next;
            op2_reg   <= op1_reg;
            zl2_reg   <= (n2_next == '0);
            n2_reg    <= n2_next;
            ps2_reg   <= ps2_next;
            mh2_reg   <= mh2_next;
            ml2_reg   <= ml2_next;
            side3_reg <= side3_next;
            tk3_reg   <= tk3_next;
            side4_reg <= side3_reg;
            h4_reg    <= h4_next;
            side5_reg <= side4_reg;
            s5_reg    <= s5_next;
            div_reg[0] <= div_next[0];
            op_reg    <= div_reg[QW].side.op;
            r_w_reg   <= r_w_next;
            r_x_reg   <= r_x_next;
            r_y_reg   <= r_y_next;
            r_z_reg   <= r_z_next;
            sat_reg   <= sat_next;
            zl_reg    <= zl_next;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.r_w         = r_w_reg;
    assign dout.r_x         = r_x_reg;
    assign dout.r_y         = r_y_reg;
    assign dout.r_z         = r_z_reg;
    assign dout.saturated   = sat_reg;
    assign dout.zero_length = zl_reg;

    `QMR_ASSERT_NOW(a_zl_clean, out_valid_reg && zl_reg,
        r_w_reg == '0 && r_x_reg == '0 && r_y_reg == '0 && r_z_reg == '0 && !sat_reg)
    `QMR_ASSERT_NOW(a_rot_w_zero, out_valid_reg && op_reg == qmr_pkg::OP_ROTATE,
        r_w_reg == '0)
    `QMR_ASSERT_NOW(a_prod_no_zl, out_valid_reg && op_reg == qmr_pkg::OP_PRODUCT,
        !zl_reg)
    `QMR_ASSERT_NEXT(a_stall_hold, !en,
        $stable(div_v_reg[QW]) && $stable(v5_reg) && $stable(v1_reg))

endmodule
